FILE: sv/slr_pkg.sv
// slr_pkg: shared constants, job type and register codes for the
// streaming literal replace core. No dependencies.
`default_nettype none

package slr_pkg;

  localparam int MaxBytes = 8;   // longest pattern or replacement
  localparam int CntW     = 4;   // holds 0..MaxBytes
  localparam int IdxW     = 3;   // indexes 0..MaxBytes-1
  localparam int QDepth   = 2;   // job queue entries
  localparam int QPtrW    = 1;
  localparam int QCntW    = 2;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] RegPatLen   = 8'd0;
  localparam logic [CfgIdxW-1:0] RegPatBytes = 8'd1;
  localparam logic [CfgIdxW-1:0] RegRepLen   = 8'd2;
  localparam logic [CfgIdxW-1:0] RegRepBytes = 8'd3;

  typedef logic [MaxBytes-1:0][7:0] slr_bytes_t;

  // one burst of output words caused by a single input word
  typedef struct packed {
    slr_bytes_t            bytes;
    logic [CntW-1:0]       nbytes;  // 1..MaxBytes
    logic                  marker;  // empty end marker, no data
    logic                  done;    // burst closes the string
  } slr_job_t;

  function automatic logic [CntW-1:0] sat_plen(input logic [3:0] v);
    logic [CntW-1:0] r;
    r = v;
    if (v == 4'd0) r = CntW'(1);
    else if (v > 4'(MaxBytes)) r = CntW'(MaxBytes);
    return r;
  endfunction

  function automatic logic [CntW-1:0] sat_rlen(input logic [3:0] v);
    logic [CntW-1:0] r;
    r = v;
    if (v > 4'(MaxBytes)) r = CntW'(MaxBytes);
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/slr_front.sv
// slr_front: accepts input words, keeps the sliding window, matches the
// pattern and posts output bursts as jobs. Holds the config registers. Uses slr_pkg.
`default_nettype none

module slr_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_byte,
  input  wire logic                          in_eos,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [slr_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [slr_pkg::CfgDataW-1:0]  cfg_wdata,
  input  wire logic                          q_full,
  output logic                               push,
  output slr_pkg::slr_job_t                  push_job
);

  logic [slr_pkg::CntW-1:0] plen_r, rlen_r;
  slr_pkg::slr_bytes_t      pat_r, rep_r;
  slr_pkg::slr_bytes_t      win_r, win_nxt, win_new;
  logic [slr_pkg::CntW-1:0] win_cnt_r, win_cnt_nxt, cnt_inc;
  logic                     in_fire, cfg_fire, hit, match;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= slr_pkg::CntW'(1);
      rlen_r <= '0;
      pat_r  <= '0;
      rep_r  <= '0;
    end else if (cfg_fire) begin
      case (cfg_index)
        slr_pkg::RegPatLen:   plen_r <= slr_pkg::sat_plen(cfg_wdata[3:0]);
        slr_pkg::RegPatBytes: pat_r  <= slr_pkg::slr_bytes_t'(cfg_wdata);
        slr_pkg::RegRepLen:   rlen_r <= slr_pkg::sat_rlen(cfg_wdata[3:0]);
        slr_pkg::RegRepBytes: rep_r  <= slr_pkg::slr_bytes_t'(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    win_new = win_r;
    win_new[win_cnt_r[slr_pkg::IdxW-1:0]] = in_byte;
    cnt_inc = win_cnt_r + slr_pkg::CntW'(1);
    hit     = cnt_inc >= plen_r;
    match   = 1'b1;
    for (int i = 0; i < slr_pkg::MaxBytes; i++) begin
      if (slr_pkg::CntW'(i) < plen_r && win_new[i] != pat_r[i]) match = 1'b0;
    end
  end

  always_comb begin
    win_nxt         = win_r;
    win_cnt_nxt     = win_cnt_r;
    push            = 1'b0;
    push_job.bytes  = win_new;
    push_job.nbytes = cnt_inc;
    push_job.marker = 1'b0;
    push_job.done   = in_eos;
    if (in_fire) begin
      win_nxt     = win_new;
      win_cnt_nxt = cnt_inc;
      if (hit && match) begin
        push_job.bytes  = rep_r;
        push_job.nbytes = rlen_r;
        win_cnt_nxt     = '0;
        push            = in_eos || (rlen_r != '0);
        if (rlen_r == '0) begin
          // match deleted at end of string: only the empty marker goes out
          push_job.bytes  = '0;
          push_job.nbytes = slr_pkg::CntW'(1);
          push_job.marker = 1'b1;
        end
      end else if (hit) begin
        for (int i = 0; i < slr_pkg::MaxBytes - 1; i++) win_nxt[i] = win_new[i+1];
        push = 1'b1;
        if (in_eos) begin
          win_cnt_nxt = '0;
        end else begin
          push_job.nbytes = slr_pkg::CntW'(1);
          win_cnt_nxt     = plen_r - slr_pkg::CntW'(1);
        end
      end else if (in_eos) begin
        push        = 1'b1;
        win_cnt_nxt = '0;
      end
    end
    if (cfg_fire && cfg_index == slr_pkg::RegPatLen) win_cnt_nxt = '0;
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) win_cnt_r <= '0;
    else        win_cnt_r <= win_cnt_nxt;
  end

`ifndef ASSERT_OFF
  a_win_below_plen: assert property (@(posedge clk) disable iff (!rst_n)
    win_cnt_r < plen_r)
    else $error("window holds a full pattern length");
  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_eos |=> win_cnt_r == '0)
    else $error("window not empty after end of string");
`endif

endmodule

`default_nettype wire

FILE: sv/slr_job_fifo.sv
// slr_job_fifo: short queue of output bursts between front and back.
// Uses slr_pkg for the job type and depth.
`default_nettype none

module slr_job_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire slr_pkg::slr_job_t push_job,
  input  wire logic              pop,
  output slr_pkg::slr_job_t      head,
  output logic                   empty,
  output logic                   full
);

  slr_pkg::slr_job_t         mem [slr_pkg::QDepth];
  logic [slr_pkg::QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [slr_pkg::QCntW-1:0] cnt_r;

  assign empty = cnt_r == '0;
  assign full  = cnt_r == slr_pkg::QCntW'(slr_pkg::QDepth);
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + slr_pkg::QPtrW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + slr_pkg::QPtrW'(1);
      cnt_r <= cnt_r + slr_pkg::QCntW'(push) - slr_pkg::QCntW'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && empty))
    else $error("job queue over- or underrun");
`endif

endmodule

`default_nettype wire

FILE: sv/slr_back.sv
// slr_back: walks the head job one word per cycle into the output register
// while it is empty or out_ready is high. Uses slr_pkg for the job type.
`default_nettype none

module slr_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire slr_pkg::slr_job_t head,
  input  wire logic              empty,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_bvalid,
  output logic                   out_lor,
  output logic                   out_done
);

  logic [slr_pkg::IdxW-1:0] idx_r, idx_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [7:0]               out_byte_r;
  logic                     out_bvalid_r, out_lor_r, out_done_r;
  logic                     load, last;

  assign load = !out_valid_r || out_ready;
  assign last = {1'b0, idx_r} == (head.nbytes - slr_pkg::CntW'(1));
  assign pop  = load && !empty && last;

  always_comb begin
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = !empty;
      if (!empty) idx_nxt = last ? '0 : idx_r + slr_pkg::IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      out_byte_r   <= head.bytes[idx_r];
      out_bvalid_r <= !head.marker;
      out_lor_r    <= last;
      out_done_r   <= last && head.done;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_bvalid = out_bvalid_r;
  assign out_lor    = out_lor_r;
  assign out_done   = out_done_r;

`ifndef ASSERT_OFF
  a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> {1'b0, idx_r} < head.nbytes)
    else $error("burst index past end of job");
`endif

endmodule

`default_nettype wire

FILE: sv/stream_literal_replace_core.sv
// stream_literal_replace_core: top level of the streaming literal replace.
// Instantiates slr_front, slr_job_fifo and slr_back; uses slr_pkg.
//
//  channel | dir | tdata / payload         | tuser                      | tlast
//  in_     | in  | [7:0] data byte         | -                          | end of string
//  out_    | out | [7:0] output byte       | [0] byte valid, [1] last   | string done
//          |     |                         |     word of input's burst  |
//  cfg_    | in  | cfg_index, cfg_wdata    | -                          | -
//
// An input word is matched in the cycle it is accepted; its burst of 0..8
// output words leaves the back end one per cycle while out_tready is high, via a
// two-entry job queue. Sustained rate is one word per cycle while each input
// word yields at most one output word and out_tready stays high; longer bursts
// hold in_tready low once the queue fills. The job queue feeds the output register.
// Reset (rst_n low, synchronous) empties window, queue and output register.
`default_nettype none

module stream_literal_replace_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,   // [7:0] data_byte
  input  wire logic                          in_tlast,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [7:0]                         out_tdata,  // [7:0] out_byte
  output logic [1:0]                         out_tuser,  // [0] byte_valid, [1] last_of_run
  output logic                               out_tlast,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [slr_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [slr_pkg::CfgDataW-1:0]  cfg_wdata
);

  logic              push, pop, q_empty, q_full;
  slr_pkg::slr_job_t push_job, head;

  slr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_eos    (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  slr_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  slr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_bvalid (out_tuser[0]),
    .out_lor    (out_tuser[1]),
    .out_done   (out_tlast)
  );

endmodule

`default_nettype wire
